/* design/dfa_pkg.sv */
package dfa_pkg;

    localparam int STATE_W = 5;
    localparam int SYM_W   = 8;
    localparam int IDX_W   = 6;
    localparam int OP_W    = 2;
    localparam int CFG_W   = 7;
    localparam int CNT_W   = 16;

    localparam int DEF_MAX_TRANSITIONS = 64;
    localparam int DEF_MAX_STATES      = 32;

    localparam logic [OP_W-1:0] OP_WR_TRANS = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_FLAG  = 2'd1;
    localparam logic [OP_W-1:0] OP_SYMBOL   = 2'd2;
    localparam logic [OP_W-1:0] OP_END      = 2'd3;

    localparam logic [SYM_W-1:0] NEWLINE_CHAR = 8'd10;
    localparam logic [CNT_W-1:0] LINE_MAX     = 16'hFFFF;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [IDX_W-1:0]   entry_index;
        logic [STATE_W-1:0] source_state;
        logic [STATE_W-1:0] target_state;
        logic [SYM_W-1:0]   symbol_char;
        logic               accept_flag;
    } t_in_item;

    typedef struct packed {
        logic             accepted;
        logic [CNT_W-1:0] sentence_number;
    } t_out_item;

    typedef struct packed {
        logic [STATE_W-1:0] src;
        logic [STATE_W-1:0] dst;
        logic [SYM_W-1:0]   sym;
    } t_trans;

    typedef struct packed {
        logic               start;
        logic [STATE_W-1:0] state;
        logic [SYM_W-1:0]   sym;
    } t_srch_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic               hit;
        logic [STATE_W-1:0] next_state;
    } t_srch_rsp;

endpackage

/* design/dfa_ram.sv */
module dfa_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/dfa_seq.sv */
module dfa_seq #(
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dfa_pkg::t_srch_req  i_req,
    input  logic [CW-1:0]       i_count,
    output logic                o_rd_en,
    output logic [AW-1:0]       o_rd_addr,
    input  dfa_pkg::t_trans     i_rd_data,
    output dfa_pkg::t_srch_rsp  o_rsp
);

    import dfa_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic               r_st, n_st;
    logic [CW-1:0]      r_idx, n_idx;
    logic               r_cmp_valid, n_cmp_valid;
    logic [STATE_W-1:0] r_state, n_state;
    logic [SYM_W-1:0]   r_sym, n_sym;
    logic               match;

    // entry read last cycle is compared while the next one is fetched
    assign match = r_cmp_valid && (i_rd_data.src == r_state) && (i_rd_data.sym == r_sym);

    always_comb begin
        n_st        = r_st;
        n_idx       = r_idx;
        n_cmp_valid = r_cmp_valid;
        n_state     = r_state;
        n_sym       = r_sym;
        o_rd_en     = 1'b0;
        o_rsp       = '0;
        o_rsp.busy  = (r_st == S_SCAN);
        o_rsp.next_state = i_rd_data.dst;
        unique case (r_st)
            S_IDLE: begin
                if (i_req.start) begin
                    n_st        = S_SCAN;
                    n_idx       = '0;
                    n_cmp_valid = 1'b0;
                    n_state     = i_req.state;
                    n_sym       = i_req.sym;
                end
            end
            S_SCAN: begin
                if (match) begin
                    o_rsp.done = 1'b1;
                    o_rsp.hit  = 1'b1;
                    n_st       = S_IDLE;
                end else if (r_idx == i_count) begin
                    o_rsp.done = 1'b1;
                    n_st       = S_IDLE;
                end else begin
                    o_rd_en     = 1'b1;
                    n_idx       = r_idx + CW'(1);
                    n_cmp_valid = 1'b1;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    assign o_rd_addr = r_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_IDLE;
            r_cmp_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_st        <= n_st;
            r_cmp_valid <= n_cmp_valid;
            r_idx       <= n_idx;
        end
        r_state <= n_state;
        r_sym   <= n_sym;
    end

endmodule

/* design/dfa_line_recognizer.sv */
// Load items and symbols that need no search are handled without a table search; a
// symbol on a live line starts a search that holds off input until it ends, one table
// entry read per cycle through the single read port of the transition memory.
// A newline or end-of-text item registers its verdict, which appears the cycle after the item is taken.
// Synchronous active-low reset clears accept flags, line state and counters;
// the transition memory is not cleared and holds garbage until written.
module dfa_line_recognizer #(
    parameter int MAX_TRANSITIONS = dfa_pkg::DEF_MAX_TRANSITIONS,
    parameter int MAX_STATES      = dfa_pkg::DEF_MAX_STATES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  dfa_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output dfa_pkg::t_out_item         o_out_data,
    input  logic                       i_cfg_we,
    input  logic [dfa_pkg::CFG_W-1:0]  i_cfg_wdata
);

    import dfa_pkg::*;

    // entry_index and state fields are narrow, so storage never exceeds their span
    localparam int TABLE_DEPTH = (MAX_TRANSITIONS < 2**IDX_W) ? MAX_TRANSITIONS : 2**IDX_W;
    localparam int FLAG_DEPTH  = (MAX_STATES < 2**STATE_W) ? MAX_STATES : 2**STATE_W;
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [CFG_W-1:0]      r_count;
    logic [FLAG_DEPTH-1:0] r_flags, n_flags;
    logic [STATE_W-1:0]    r_cur, n_cur;
    logic [STATE_W-1:0]    r_start;
    logic                  r_alive, n_alive;
    logic                  r_at_start, n_at_start;
    logic [CNT_W-1:0]      r_line, n_line;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;

    logic          in_xfer;
    logic          is_finish;
    logic          is_feed;
    logic          tbl_we;
    logic [CW-1:0] active;
    logic [STATE_W-1:0] eff_state;
    logic          eff_final;
    t_trans        wr_entry;
    t_trans        rd_entry;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_srch_req     req;
    t_srch_rsp     rsp;

    assign o_in_ready = !rsp.busy && (!r_out_valid || i_out_ready);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign is_finish  = (i_in_data.op == OP_END) ||
                        (i_in_data.op == OP_SYMBOL && i_in_data.symbol_char == NEWLINE_CHAR);
    assign is_feed    = (i_in_data.op == OP_SYMBOL) && (i_in_data.symbol_char != NEWLINE_CHAR);

    assign active = (r_count > CFG_W'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : r_count[CW-1:0];

    assign tbl_we = in_xfer && (i_in_data.op == OP_WR_TRANS) &&
                    (32'(i_in_data.entry_index) < MAX_TRANSITIONS);
    assign wr_entry.src = i_in_data.source_state;
    assign wr_entry.dst = i_in_data.target_state;
    assign wr_entry.sym = i_in_data.symbol_char;

    assign eff_state = r_at_start ? r_start : r_cur;

    always_comb begin
        eff_final = 1'b0;
        for (int i = 0; i < FLAG_DEPTH; i++) begin
            if (eff_state == STATE_W'(i)) begin
                eff_final = r_flags[i];
            end
        end
    end

    assign req.start = in_xfer && is_feed && r_alive && (active != '0);
    assign req.state = eff_state;
    assign req.sym   = i_in_data.symbol_char;

    always_comb begin
        n_flags     = r_flags;
        n_cur       = r_cur;
        n_alive     = r_alive;
        n_at_start  = r_at_start;
        n_line      = r_line;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (rsp.done) begin
            if (rsp.hit) begin
                n_cur = rsp.next_state;
            end else begin
                n_alive = 1'b0;
            end
        end

        if (in_xfer) begin
            if (i_in_data.op == OP_WR_FLAG) begin
                for (int i = 0; i < FLAG_DEPTH; i++) begin
                    if (i_in_data.source_state == STATE_W'(i)) begin
                        n_flags[i] = i_in_data.accept_flag;
                    end
                end
            end else if (is_finish) begin
                n_out.accepted        = r_alive && (active != '0) && eff_final;
                n_out.sentence_number = r_line;
                n_out_valid           = 1'b1;
                n_line     = (r_line == LINE_MAX) ? CNT_W'(1) : r_line + CNT_W'(1);
                n_alive    = 1'b1;
                n_at_start = 1'b1;
                n_cur      = r_start;
            end else if (is_feed) begin
                n_at_start = 1'b0;
                n_cur      = eff_state;
                // empty table: nothing can match
                if (r_alive && active == '0) begin
                    n_alive = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_flags     <= '0;
            r_cur       <= '0;
            r_alive     <= 1'b1;
            r_at_start  <= 1'b1;
            r_line      <= CNT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            r_flags     <= n_flags;
            r_cur       <= n_cur;
            r_alive     <= n_alive;
            r_at_start  <= n_at_start;
            r_line      <= n_line;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
        // start state mirrors the source of entry zero
        if (tbl_we && i_in_data.entry_index == '0) begin
            r_start <= i_in_data.source_state;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    dfa_ram #(
        .WIDTH ($bits(t_trans)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (i_in_data.entry_index[AW-1:0]),
        .i_wdata (wr_entry),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_entry)
    );

    dfa_seq #(
        .DEPTH (TABLE_DEPTH)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .i_count   (active),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_entry),
        .o_rsp     (rsp)
    );

endmodule
